// File: src/bcs_pkg.sv
// Shared types and constants for the bucket counting sort unit.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int unsigned KEY_W      = 7;
  localparam int unsigned IDX_OUT_W  = 6;
  localparam int unsigned CFG_W      = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_PFX,
    ST_SC_KEY,
    ST_SC_CUR,
    ST_SC_WR,
    ST_OUT
  } bcs_state_t;

endpackage

// File: src/bcs_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module bcs_ram #(
  parameter int unsigned DW    = 7,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/bucket_counting_sort_unit.sv
// Stable counting sort of one set of keyed requests; top level and sequencer.
// Loading takes one request per cycle; the tally memory is updated read-modify-write
// with forwarding between neighboring requests to the same bucket.
// After the last request: drain, a prefix-sum pass over the buckets, a scatter of
// each item in key-read, cursor-read and write steps, one result per cycle, then a
// tally clear. An error set gives its single result after the drain, then clears.
// Reset (synchronous, rst_n low) starts a clearing pass over all buckets, busy high.
`timescale 1ns / 1ps
module bucket_counting_sort_unit
  import bcs_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 64,
  parameter int unsigned MAX_ITEMS   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_W-1:0]     in_owner_key,
  input  logic                 in_last_item,
  output logic                 out_valid,
  output logic [IDX_OUT_W-1:0] out_item_index,
  output logic [KEY_W-1:0]     out_bucket,
  output logic                 out_error,
  output logic                 out_last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_bucket_count
);

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = KEY_W + IW;
  localparam logic [BW-1:0] B_LAST = BW'(NUM_BUCKETS - 1);
  localparam logic [CW-1:0] N_MAX  = CW'(MAX_ITEMS);

  bcs_state_t state_r, state_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [IW-1:0]    ix_r, ix_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic [CW-1:0]    run_r, run_nxt;
  logic             ld_v_r, ld_v_nxt;
  logic [BW-1:0]    ld_addr_r, ld_addr_nxt;
  logic             ld_fwd_r, ld_fwd_nxt;
  logic [CW-1:0]    ld_fwd_data_r, ld_fwd_data_nxt;
  logic             pf_pend_r, pf_pend_nxt;
  logic [BW-1:0]    pf_addr_r, pf_addr_nxt;
  logic [KEY_W-1:0] sc_key_r, sc_key_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_error_r, out_error_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CFG_W-1:0] bucket_count_r, bucket_count_nxt;

  logic          t_we, t_re;
  logic [BW-1:0] t_waddr, t_raddr;
  logic [CW-1:0] t_wdata, t_rdata;
  logic             k_we, k_re;
  logic [IW-1:0]    k_waddr, k_raddr;
  logic [KEY_W-1:0] k_wdata, k_rdata;
  logic          s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic          accept;
  logic          key_ok;
  logic [BW-1:0] key_addr;
  logic [CW-1:0] ld_new;
  logic          ix_last;

  // Tally memory holds per-bucket counts during loading and running cursors
  // after the prefix pass.
  bcs_ram #(.DW(CW), .DEPTH(NUM_BUCKETS), .AW(BW)) u_tally (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  bcs_ram #(.DW(KEY_W), .DEPTH(MAX_ITEMS), .AW(IW)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  // Sorted memory holds {key, arrival index} at each sorted position.
  bcs_ram #(.DW(SW), .DEPTH(MAX_ITEMS), .AW(IW)) u_sorted (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign key_ok    = (in_owner_key != '0) && (in_owner_key <= bucket_count_r)
                     && (32'(in_owner_key) <= NUM_BUCKETS);
  assign key_addr  = BW'(32'(in_owner_key) - 32'd1);
  assign ld_new    = (ld_fwd_r ? ld_fwd_data_r : t_rdata) + CW'(1);
  assign ix_last   = (CW'(ix_r) == (cnt_r - CW'(1)));

  always_comb begin
    state_nxt        = state_r;
    b_nxt            = b_r;
    ix_nxt           = ix_r;
    cnt_nxt          = cnt_r;
    err_nxt          = err_r;
    run_nxt          = run_r;
    ld_v_nxt         = 1'b0;
    ld_addr_nxt      = ld_addr_r;
    ld_fwd_nxt       = 1'b0;
    ld_fwd_data_nxt  = ld_fwd_data_r;
    pf_pend_nxt      = 1'b0;
    pf_addr_nxt      = pf_addr_r;
    sc_key_nxt       = sc_key_r;
    out_valid_nxt    = 1'b0;
    out_error_nxt    = 1'b0;
    out_last_nxt     = 1'b0;
    bucket_count_nxt = (cfg_valid && cfg_ready) ? cfg_bucket_count : bucket_count_r;

    t_we    = 1'b0;
    t_waddr = ld_addr_r;
    t_wdata = ld_new;
    t_re    = 1'b0;
    t_raddr = key_addr;
    k_we    = 1'b0;
    k_waddr = cnt_r[IW-1:0];
    k_wdata = in_owner_key;
    k_re    = 1'b0;
    k_raddr = ix_r;
    s_we    = 1'b0;
    s_waddr = t_rdata[IW-1:0];
    s_wdata = {sc_key_r, ix_r};
    s_re    = 1'b0;
    s_raddr = ix_r;

    // Write-back of a counted request issued in the previous cycle.
    if (ld_v_r) begin
      t_we = 1'b1;
    end

    // Write-back of the exclusive prefix sum for the bucket read last cycle.
    if (pf_pend_r) begin
      t_we    = 1'b1;
      t_waddr = pf_addr_r;
      t_wdata = run_r;
      run_nxt = run_r + t_rdata;
    end

    case (state_r)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = b_r;
        t_wdata = '0;
        cnt_nxt = '0;
        err_nxt = 1'b0;
        run_nxt = '0;
        ix_nxt  = '0;
        if (b_r == B_LAST) begin
          b_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          b_nxt = b_r + BW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cnt_r < N_MAX) begin
            k_we    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (key_ok) begin
              t_re            = 1'b1;
              ld_v_nxt        = 1'b1;
              ld_addr_nxt     = key_addr;
              // The write landing at this edge would be missed by the read.
              ld_fwd_nxt      = ld_v_r && (ld_addr_r == key_addr);
              ld_fwd_data_nxt = ld_new;
            end else begin
              err_nxt = 1'b1;
            end
          end else begin
            err_nxt = 1'b1;
          end
          if (in_last_item) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (err_r) begin
          out_valid_nxt = 1'b1;
          out_error_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_CLEAR;
        end else begin
          state_nxt = ST_PFX;
        end
      end
      ST_PFX: begin
        t_re        = 1'b1;
        t_raddr     = b_r;
        pf_pend_nxt = 1'b1;
        pf_addr_nxt = b_r;
        if (b_r == B_LAST) begin
          b_nxt     = '0;
          ix_nxt    = '0;
          state_nxt = ST_SC_KEY;
        end else begin
          b_nxt = b_r + BW'(1);
        end
      end
      ST_SC_KEY: begin
        k_re      = 1'b1;
        state_nxt = ST_SC_CUR;
      end
      ST_SC_CUR: begin
        sc_key_nxt = k_rdata;
        t_re       = 1'b1;
        t_raddr    = BW'(32'(k_rdata) - 32'd1);
        state_nxt  = ST_SC_WR;
      end
      ST_SC_WR: begin
        t_we    = 1'b1;
        t_waddr = BW'(32'(sc_key_r) - 32'd1);
        t_wdata = t_rdata + CW'(1);
        s_we    = 1'b1;
        if (ix_last) begin
          ix_nxt    = '0;
          state_nxt = ST_OUT;
        end else begin
          ix_nxt    = ix_r + IW'(1);
          state_nxt = ST_SC_KEY;
        end
      end
      ST_OUT: begin
        s_re          = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = ix_last;
        if (ix_last) begin
          ix_nxt    = '0;
          state_nxt = ST_CLEAR;
        end else begin
          ix_nxt = ix_r + IW'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      b_r            <= '0;
      ix_r           <= '0;
      cnt_r          <= '0;
      err_r          <= 1'b0;
      run_r          <= '0;
      ld_v_r         <= 1'b0;
      ld_fwd_r       <= 1'b0;
      pf_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      out_error_r    <= 1'b0;
      out_last_r     <= 1'b0;
      bucket_count_r <= CFG_RESET;
    end else begin
      state_r        <= state_nxt;
      b_r            <= b_nxt;
      ix_r           <= ix_nxt;
      cnt_r          <= cnt_nxt;
      err_r          <= err_nxt;
      run_r          <= run_nxt;
      ld_v_r         <= ld_v_nxt;
      ld_fwd_r       <= ld_fwd_nxt;
      pf_pend_r      <= pf_pend_nxt;
      out_valid_r    <= out_valid_nxt;
      out_error_r    <= out_error_nxt;
      out_last_r     <= out_last_nxt;
      bucket_count_r <= bucket_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r     <= ld_addr_nxt;
    ld_fwd_data_r <= ld_fwd_data_nxt;
    pf_addr_r     <= pf_addr_nxt;
    sc_key_r      <= sc_key_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_error       = out_error_r;
  assign out_last_result = out_last_r;
  assign out_item_index  = out_error_r ? '0 : IDX_OUT_W'(s_rdata[IW-1:0]);
  assign out_bucket      = out_error_r ? '0 : s_rdata[SW-1:IW];

endmodule

// File: src/bcs_checker.sv
// Port-level checker for the bucket counting sort unit, bound to the top level.
`timescale 1ns / 1ps
module bcs_checker
  import bcs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_last_item,
  input logic                 out_valid,
  input logic [IDX_OUT_W-1:0] out_item_index,
  input logic [KEY_W-1:0]     out_bucket,
  input logic                 out_error,
  input logic                 out_last_result
);

  // A reset always starts the clearing pass, so no request is taken right after it.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // The last request of a set closes the loading phase.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_item |=> busy)
    else $error("not busy after the last request of a set");

  // Results only appear while a set is being sorted or cleared.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  // An error result stands alone with zeroed payload.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last_result && out_bucket == '0
                               && out_item_index == '0)
    else $error("malformed error result");

  // A sorted result always names a real bucket.
  a_ok_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_bucket != '0)
    else $error("sorted result with bucket zero");

endmodule

bind bucket_counting_sort_unit bcs_checker u_bcs_checker (.*);
